// File: hw/rtl/mgr_pkg.sv
// ----------------------------------------------------------------------------
// mgr_pkg: shared types and constants of the gesture ratchet
// Beat structs, command, kind and direction codes, sequencer states.
// ----------------------------------------------------------------------------
package mgr_pkg;

  localparam int SET_COUNT_DEF   = 4;
  localparam int BURST_LIMIT_DEF = 8;
  localparam int TRAVEL_BITS_DEF = 24;

  localparam logic [10:0] STEP_MIN   = 11'd50;
  localparam logic [10:0] STEP_MAX   = 11'd2000;
  localparam logic [10:0] STEP_RESET = 11'd150;

  localparam logic [17:0] TAN22_Q16 = 18'd26478;
  localparam logic [17:0] TAN23_Q16 = 18'd27818;
  localparam logic [17:0] TAN67_Q16 = 18'd154393;
  localparam logic [17:0] TAN68_Q16 = 18'd162207;

  localparam int KEEP_BITS = 16;

  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [3:0] REG_ENABLED = 4'd0;
  localparam logic [3:0] REG_STEP    = 4'd1;
  localparam logic [3:0] REG_DEFSET  = 4'd2;
  localparam logic [3:0] REG_DIAG    = 4'd3;

  localparam logic [2:0] DIR_E  = 3'd0;
  localparam logic [2:0] DIR_SE = 3'd1;
  localparam logic [2:0] DIR_S  = 3'd2;
  localparam logic [2:0] DIR_SW = 3'd3;
  localparam logic [2:0] DIR_W  = 3'd4;
  localparam logic [2:0] DIR_NW = 3'd5;
  localparam logic [2:0] DIR_N  = 3'd6;
  localparam logic [2:0] DIR_NE = 3'd7;

  typedef enum logic [1:0] {
    KIND_FIRE    = 2'd0,
    KIND_PASS    = 2'd1,
    KIND_SWALLOW = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LAST, ST_MX, ST_MY, ST_MC, ST_CMP, ST_T1, ST_T2, ST_T3,
    ST_FIRE, ST_SQ, ST_CHK, ST_DV, ST_SX, ST_SY, ST_SW
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               is_relative;
    logic [1:0]         axis;
    logic signed [15:0] delta;
    logic               follow_active;
    logic [7:0]         requested_set;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] out_set;
    logic [2:0] direction;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic x_neg;
    logic y_pos;
    logic y_neg;
    logic ax_ge_ay;
    logic horiz;
    logic diag;
  } dir_ctl_t;

endpackage

// File: hw/rtl/mgr_dir.sv
// ----------------------------------------------------------------------------
// mgr_dir: 8-way direction resolve
// Maps band compares to a sector and falls back to a cardinal on an empty
// diagonal.
// ----------------------------------------------------------------------------
module mgr_dir import mgr_pkg::*; #(
  parameter int SET_BITS = 2
) (
  input  dir_ctl_t            ctl_i,
  input  logic [SET_BITS-1:0] set_i,
  input  logic [15:0]         mask_i,
  output logic [2:0]          dir_o
);

  logic [2:0]          sector;
  logic [SET_BITS+3:0] bitpos;
  logic                present;

  always_comb begin
    if (ctl_i.horiz) begin
      sector = ctl_i.x_neg ? DIR_W : DIR_E;
    end else if (ctl_i.diag) begin
      if (ctl_i.x_neg) sector = ctl_i.y_pos ? DIR_SW : DIR_NW;
      else             sector = ctl_i.y_pos ? DIR_SE : DIR_NE;
    end else begin
      sector = ctl_i.y_pos ? DIR_S : DIR_N;
    end
    bitpos  = {2'b00, set_i, sector[2:1]};
    present = (32'(bitpos) < 32'd16) && mask_i[bitpos[3:0]];
    if (!sector[0] || present) begin
      dir_o = sector;
    end else if (ctl_i.ax_ge_ay) begin
      dir_o = ctl_i.x_neg ? DIR_W : DIR_E;
    end else begin
      dir_o = ctl_i.y_neg ? DIR_N : DIR_S;
    end
  end

endmodule

// File: hw/rtl/motion_gesture_ratchet_core.sv
// ----------------------------------------------------------------------------
// motion_gesture_ratchet_core: 8-way gesture ratchet for pointer motion
// Swallows relative motion during a gesture, accumulates travel and fires
// a direction each time the travel reaches the ratchet step.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake           Payload
// in       in   in_valid/in_ready   in_item_t   (one command or event)
// out      out  out_valid/out_ready out_item_t  (1..BURST_LIMIT+1 beats)
// cfg      in   cfg_we              index 4b, data 16b (no wait)
//
// A command or pass-through event goes from ST_IDLE to ST_LAST. A swallowed X/Y
// event tests the travel with the squares in ST_MX..ST_CMP; each fire then
// runs the tangent compares, a bit-serial square root, a bit-serial divide
// and the rescale. The shared multiplier is used for squares, tangent
// compares and rescale.
// The input is held off while an item is in work; a result beat waiting in
// the output register stalls the sequencer only when the next beat is due.
// Reset closes the gesture, clears travel and loads register defaults.
// ----------------------------------------------------------------------------
module motion_gesture_ratchet_core import mgr_pkg::*; #(
  parameter int SET_COUNT   = SET_COUNT_DEF,
  parameter int BURST_LIMIT = BURST_LIMIT_DEF,
  parameter int TRAVEL_BITS = TRAVEL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int TB    = TRAVEL_BITS;
  localparam int SETW  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int OPW   = (TB > 18) ? TB : 18;
  localparam int PW    = 2 * OPW;
  localparam int D2W   = 2 * TB;
  localparam int CNTW  = $clog2(TB + 1);
  localparam int BW    = $clog2(BURST_LIMIT + 1);
  localparam logic [7:0] SET_LAST = 8'(SET_COUNT - 1);

  // configuration
  logic        enabled_q;
  logic [10:0] step_q;
  logic [21:0] step2_q;
  logic [1:0]  defset_q;
  logic [15:0] mask_q;

  // gesture state
  logic                 open_q;
  logic [SETW-1:0]      cur_q;
  logic signed [TB-1:0] tx_q, ty_q;

  // sequencer and datapath
  state_e              state_q, state_d;
  kind_e               kind_q;
  logic [BW-1:0]       burst_q;
  logic [PW-1:0]       prod_q;
  logic [D2W-1:0]      d2_q;
  logic                lo_q, hi_q;
  logic [D2W-1:0]      sqn_q;
  logic [TB+2:0]       sqrem_q;
  logic [TB-1:0]       root_q;
  logic [TB:0]         dvrem_q;
  logic [KEEP_BITS-1:0] keep_q;
  logic [CNTW-1:0]     cnt_q;

  logic      out_valid_q;
  out_item_t out_q;

  // magnitudes, multiplier
  logic [TB-1:0]  ax, ay;
  logic [OPW-1:0] mul_a, mul_b;
  logic [PW-1:0]  ys;
  logic           band_hit;
  logic           can_put;
  logic           accept;
  logic [10:0]    step_clamp;

  assign ax = tx_q[TB-1] ? TB'(-tx_q) : TB'(tx_q);
  assign ay = ty_q[TB-1] ? TB'(-ty_q) : TB'(ty_q);
  assign ys = PW'(ay) << 16;
  // x >= 0 uses strict bounds, x < 0 inclusive ones
  assign band_hit = tx_q[TB-1] ? (ys <= prod_q) : (ys < prod_q);
  assign can_put  = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    mul_a = OPW'(ax);
    mul_b = OPW'(ax);
    case (state_q)
      ST_MY: begin
        mul_a = OPW'(ay);
        mul_b = OPW'(ay);
      end
      ST_T1: mul_b = OPW'(tx_q[TB-1] ? TAN22_Q16 : TAN23_Q16);
      ST_T2: mul_b = OPW'(tx_q[TB-1] ? TAN67_Q16 : TAN68_Q16);
      ST_SX: mul_b = OPW'(keep_q);
      ST_SY: begin
        mul_a = OPW'(ay);
        mul_b = OPW'(keep_q);
      end
      default: ;
    endcase
  end

  // direction resolve
  dir_ctl_t   dctl;
  logic [2:0] fire_dir;

  assign dctl.x_neg    = tx_q[TB-1];
  assign dctl.y_neg    = ty_q[TB-1];
  assign dctl.y_pos    = !ty_q[TB-1] && (ty_q != '0);
  assign dctl.ax_ge_ay = (ax >= ay);
  assign dctl.horiz    = lo_q;
  assign dctl.diag     = hi_q;

  mgr_dir #(.SET_BITS(SETW)) u_dir (
    .ctl_i  (dctl),
    .set_i  (cur_q),
    .mask_i (mask_q),
    .dir_o  (fire_dir)
  );

  // sqrt and divide steps
  logic [TB+2:0] sq_sh, sq_trial;
  logic          sq_ge;
  logic [TB:0]   dv_sh;
  logic          dv_ge;

  assign sq_sh    = {sqrem_q[TB:0], sqn_q[D2W-1:D2W-2]};
  assign sq_trial = (TB+3)'({root_q, 2'b01});
  assign sq_ge    = (sq_sh >= sq_trial);
  assign dv_sh    = {dvrem_q[TB-1:0], 1'b0};
  assign dv_ge    = (dv_sh >= {1'b0, root_q});

  // travel accumulate with saturation
  logic signed [TB:0]   acc_sum;
  logic signed [TB-1:0] acc_sat;
  logic signed [TB-1:0] acc_old;
  localparam logic signed [TB:0] TMAX = (TB+1)'((1 << (TB - 1)) - 1);
  localparam logic signed [TB:0] TMIN = -TMAX - (TB+1)'(1);

  assign acc_old = (in_data_i.axis == AXIS_X) ? tx_q : ty_q;
  assign acc_sum = (TB+1)'(acc_old) + (TB+1)'(in_data_i.delta);
  always_comb begin
    if (acc_sum > TMAX)      acc_sat = TB'(TMAX);
    else if (acc_sum < TMIN) acc_sat = TB'(TMIN);
    else                     acc_sat = TB'(acc_sum);
  end

  assign step_clamp = (cfg_data_i[10:0] < STEP_MIN) ? STEP_MIN :
                      (cfg_data_i[10:0] > STEP_MAX) ? STEP_MAX : cfg_data_i[10:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == CMD_EVENT && open_q && in_data_i.is_relative &&
              (in_data_i.axis == AXIS_X || in_data_i.axis == AXIS_Y)) begin
            state_d = ST_MX;
          end else begin
            state_d = ST_LAST;
          end
        end
      end
      ST_LAST: if (can_put) state_d = ST_IDLE;
      ST_MX:   state_d = ST_MY;
      ST_MY:   state_d = ST_MC;
      ST_MC:   state_d = ST_CMP;
      ST_CMP:  state_d = (d2_q < D2W'(step2_q)) ? ST_LAST : ST_T1;
      ST_T1:   state_d = ST_T2;
      ST_T2:   state_d = ST_T3;
      ST_T3:   state_d = ST_FIRE;
      ST_FIRE: if (can_put) state_d = ST_SQ;
      ST_SQ:   if (cnt_q == CNTW'(1)) state_d = ST_CHK;
      ST_CHK:  state_d = (root_q <= TB'(step_q)) ? ST_LAST : ST_DV;
      ST_DV:   if (cnt_q == CNTW'(1)) state_d = ST_SX;
      ST_SX:   state_d = ST_SY;
      ST_SY:   state_d = ST_SW;
      ST_SW:   state_d = (burst_q == '0) ? ST_LAST : ST_MX;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // control: config, gesture state, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      step_q      <= STEP_RESET;
      step2_q     <= 22'(STEP_RESET) * 22'(STEP_RESET);
      defset_q    <= '0;
      mask_q      <= '0;
      open_q      <= 1'b0;
      cur_q       <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      kind_q      <= KIND_DONE;
      burst_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLED: begin
            enabled_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              open_q <= 1'b0;
              tx_q   <= '0;
              ty_q   <= '0;
            end
          end
          REG_STEP: begin
            step_q  <= step_clamp;
            step2_q <= 22'(step_clamp) * 22'(step_clamp);
          end
          REG_DEFSET: defset_q <= cfg_data_i[1:0];
          REG_DIAG:   mask_q   <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q <= KIND_DONE;
            case (in_data_i.cmd)
              CMD_BEGIN: begin
                if (enabled_q) begin
                  if ((in_data_i.follow_active ? 8'(defset_q) : in_data_i.requested_set)
                      > SET_LAST) begin
                    cur_q <= SETW'(SET_LAST);
                  end else begin
                    cur_q <= in_data_i.follow_active ? SETW'(defset_q)
                                                     : SETW'(in_data_i.requested_set);
                  end
                  open_q <= 1'b1;
                  tx_q   <= '0;
                  ty_q   <= '0;
                end
              end
              CMD_END: begin
                open_q <= 1'b0;
                tx_q   <= '0;
                ty_q   <= '0;
              end
              CMD_EVENT: begin
                if (!open_q || !in_data_i.is_relative) begin
                  kind_q <= KIND_PASS;
                end else begin
                  kind_q  <= KIND_SWALLOW;
                  burst_q <= BW'(BURST_LIMIT);
                  if (in_data_i.axis == AXIS_X)      tx_q <= acc_sat;
                  else if (in_data_i.axis == AXIS_Y) ty_q <= acc_sat;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LAST: begin
          if (can_put) begin
            out_valid_q <= 1'b1;
            out_q       <= '{kind: kind_q, out_set: 2'b00, direction: DIR_E, last: 1'b1};
          end
        end
        ST_FIRE: begin
          if (can_put) begin
            out_valid_q <= 1'b1;
            out_q       <= '{kind: KIND_FIRE, out_set: 2'(cur_q), direction: fire_dir,
                             last: 1'b0};
            burst_q     <= burst_q - BW'(1);
            cnt_q       <= CNTW'(TB);
          end
        end
        ST_SQ: cnt_q <= cnt_q - CNTW'(1);
        ST_CHK: begin
          cnt_q <= CNTW'(KEEP_BITS);
          // travel used up: clear and stop
          if (root_q <= TB'(step_q)) begin
            tx_q <= '0;
            ty_q <= '0;
          end
        end
        ST_DV: cnt_q <= cnt_q - CNTW'(1);
        ST_SY: tx_q <= tx_q[TB-1] ? -$signed(prod_q[TB+15:16]) : $signed(prod_q[TB+15:16]);
        ST_SW: ty_q <= ty_q[TB-1] ? -$signed(prod_q[TB+15:16]) : $signed(prod_q[TB+15:16]);
        default: ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a) * PW'(mul_b);
    case (state_q)
      ST_MY: d2_q <= prod_q[D2W-1:0];
      ST_MC: d2_q <= d2_q + prod_q[D2W-1:0];
      ST_T2: lo_q <= band_hit;
      ST_T3: hi_q <= band_hit;
      ST_FIRE: begin
        sqn_q   <= d2_q;
        sqrem_q <= '0;
        root_q  <= '0;
      end
      ST_SQ: begin
        sqn_q   <= sqn_q << 2;
        sqrem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_q  <= {root_q[TB-2:0], sq_ge};
      end
      ST_CHK: begin
        dvrem_q <= (TB+1)'(root_q) - (TB+1)'(step_q);
        keep_q  <= '0;
      end
      ST_DV: begin
        dvrem_q <= dv_ge ? (dv_sh - {1'b0, root_q}) : dv_sh;
        keep_q  <= {keep_q[KEEP_BITS-2:0], dv_ge};
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/motion_gesture_ratchet_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_gesture_ratchet_core_test: self-checking bench for the gesture ratchet
// Drives commands and motion events with random gaps, predicts every result
// beat with an independent ratchet model and compares beats in order.
// ----------------------------------------------------------------------------
module motion_gesture_ratchet_core_test;
  import mgr_pkg::*;

  localparam int TRAVEL_HI = (1 << 23) - 1;
  localparam int TRAVEL_LO = -(1 << 23);

  // Scoreboard: ratchet predictor plus the queue of beats still owed.
  class ratchet_scoreboard;
    bit              en;
    logic [10:0]     step;
    logic [1:0]      def_set;
    logic [15:0]     diag_mask;
    bit              open;
    logic [1:0]      cur_set;
    longint          tx;
    longint          ty;
    out_item_t       owed[$];
    int              mismatches;
    int              beats_checked;
    int              fires_seen;

    function new();
      en = 1;
      step = STEP_RESET;
      def_set = 0;
      diag_mask = 0;
      open = 0;
      cur_set = 0;
      tx = 0;
      ty = 0;
      mismatches = 0;
      beats_checked = 0;
      fires_seen = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] val);
      logic [10:0] s;
      s = val[10:0];
      case (idx)
        REG_ENABLED: begin
          en = val[0];
          if (!en) begin
            open = 0;
            tx = 0;
            ty = 0;
          end
        end
        REG_STEP: begin
          if (s < STEP_MIN) s = STEP_MIN;
          if (s > STEP_MAX) s = STEP_MAX;
          step = s;
        end
        REG_DEFSET: def_set = val[1:0];
        REG_DIAG: diag_mask = val;
        default: ;
      endcase
    endfunction

    function void owe(kind_e k, logic [1:0] st, logic [2:0] dir, logic lst);
      out_item_t b;
      b.kind = k;
      b.out_set = st;
      b.direction = dir;
      b.last = lst;
      owed.push_back(b);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // 8-way sector of the travel vector, then fall back to the cardinal
    // when the diagonal is not populated for this set.
    function logic [2:0] heading(longint x, longint y);
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned ys;
      logic [2:0] d;
      int pos;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      ys = ay << 16;
      if (x >= 0) begin
        if (ys < ax * TAN23_Q16) d = DIR_E;
        else if (ys < ax * TAN68_Q16) d = y > 0 ? DIR_SE : DIR_NE;
        else d = y > 0 ? DIR_S : DIR_N;
      end else begin
        if (ys <= ax * TAN22_Q16) d = DIR_W;
        else if (ys <= ax * TAN67_Q16) d = y > 0 ? DIR_SW : DIR_NW;
        else d = y > 0 ? DIR_S : DIR_N;
      end
      if (d[0]) begin
        pos = cur_set * 4 + d[2:1];
        if (!(pos < 16 && diag_mask[pos])) begin
          if (ax >= ay) d = x >= 0 ? DIR_E : DIR_W;
          else d = y >= 0 ? DIR_S : DIR_N;
        end
      end
      return d;
    endfunction

    // Note an accepted input beat and queue the beats it should cause.
    function void note_input(in_item_t it);
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned d;
      longint unsigned keep;
      longint unsigned nx;
      longint unsigned ny;
      int burst;
      logic [7:0] s;
      if (it.cmd == CMD_BEGIN) begin
        if (en) begin
          s = it.follow_active ? def_set : it.requested_set;
          if (s > 3) s = 3;
          cur_set = s[1:0];
          open = 1;
          tx = 0;
          ty = 0;
        end
        owe(KIND_DONE, 0, 0, 1);
        return;
      end
      if (it.cmd != CMD_EVENT) begin
        if (it.cmd == CMD_END) begin
          open = 0;
          tx = 0;
          ty = 0;
        end
        owe(KIND_DONE, 0, 0, 1);
        return;
      end
      if (!open || !it.is_relative) begin
        owe(KIND_PASS, 0, 0, 1);
        return;
      end
      if (it.axis == AXIS_X) tx += longint'(it.delta);
      else if (it.axis == AXIS_Y) ty += longint'(it.delta);
      else begin
        owe(KIND_SWALLOW, 0, 0, 1);
        return;
      end
      if (tx > TRAVEL_HI) tx = TRAVEL_HI;
      if (tx < TRAVEL_LO) tx = TRAVEL_LO;
      if (ty > TRAVEL_HI) ty = TRAVEL_HI;
      if (ty < TRAVEL_LO) ty = TRAVEL_LO;
      burst = BURST_LIMIT_DEF;
      while (burst > 0) begin
        ax = tx < 0 ? -tx : tx;
        ay = ty < 0 ? -ty : ty;
        if (ax * ax + ay * ay < longint'(step) * step) break;
        burst--;
        owe(KIND_FIRE, cur_set, heading(tx, ty), 0);
        d = root(ax * ax + ay * ay);
        if (d <= step) begin
          tx = 0;
          ty = 0;
          break;
        end
        keep = ((d - step) << 16) / d;
        nx = (ax * keep) >> 16;
        ny = (ay * keep) >> 16;
        tx = tx < 0 ? -longint'(nx) : longint'(nx);
        ty = ty < 0 ? -longint'(ny) : longint'(ny);
      end
      owe(KIND_SWALLOW, 0, 0, 1);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_b;
      beats_checked++;
      if (got.kind == KIND_FIRE) fires_seen++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat kind=%0d set=%0d dir=%0d last=%0d",
                   got.kind, got.out_set, got.direction, got.last);
        return;
      end
      exp_b = owed.pop_front();
      if (got.kind !== exp_b.kind || got.out_set !== exp_b.out_set ||
          got.direction !== exp_b.direction || got.last !== exp_b.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp kind=%0d set=%0d dir=%0d last=%0d, ",
                    "got kind=%0d set=%0d dir=%0d last=%0d"},
                   exp_b.kind, exp_b.out_set, exp_b.direction, exp_b.last,
                   got.kind, got.out_set, got.direction, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [3:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  ratchet_scoreboard sb;
  bit quiet_tail;      // no idling on either side in the last part
  int stall_hold;      // long receiver hold-off, in cycles
  int items_sent;

  motion_gesture_ratchet_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit, well above the slowest correct run.
  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    int gap;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (stall_hold > 0) begin
        out_ready_i <= 0;
        stall_hold--;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        out_ready_i <= 0;
        repeat (gap - 1) begin
          @(posedge clk_i);
          if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
        end
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // Offer one beat and hold it until accepted; note it at acceptance.
  // Valid stays high into the next beat unless an idle gap is drawn.
  task automatic send_beat(in_item_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    items_sent++;
  endtask

  function automatic in_item_t mk(logic [1:0] c, logic rel, logic [1:0] ax,
                                  logic signed [15:0] dl, logic fa, logic [7:0] rs);
    in_item_t it;
    it.cmd = c;
    it.is_relative = rel;
    it.axis = ax;
    it.delta = dl;
    it.follow_active = fa;
    it.requested_set = rs;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return mk(CMD_BEGIN, 1'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                8'($urandom));
    if (r == 1)
      return mk(CMD_END, 1'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                8'($urandom));
    if (r == 2)
      return mk(2'd3, 1'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                8'($urandom));
    if (r == 3)
      return mk(CMD_EVENT, 1'($urandom), 2'($urandom), 16'($urandom), 1'($urandom),
                8'($urandom));
    // Mostly swallowed motion of moderate size, now and then a huge jump.
    return mk(CMD_EVENT, 1, 2'($urandom_range(0, 1)),
              (r == 4) ? 16'($urandom) : 16'($signed($urandom_range(0, 700)) - 350),
              1'($urandom), 8'($urandom));
  endfunction

  task automatic wait_drained();
    in_valid_i <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    // A beat causing no result cannot occur, but let the sequencer settle.
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    repeat (n) send_beat(random_item());
  endtask

  initial begin
    sb = new();
    quiet_tail = 0;
    stall_hold = 0;
    items_sent = 0;
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    cfg_we_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: commands while closed, pass-through, then gestures on both axes in both signs.
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sd100, 0, 0));
    send_beat(mk(CMD_END, 0, 0, 0, 0, 0));
    send_beat(mk(2'd3, 1, 2'd3, 16'h8000, 1, 8'hFF));
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 0, 8'd200));
    send_beat(mk(CMD_EVENT, 0, AXIS_X, 16'sd500, 0, 0));
    send_beat(mk(CMD_EVENT, 1, 2'd2, 16'sd500, 0, 0));
    send_beat(mk(CMD_EVENT, 1, 2'd3, 16'sd500, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sd150, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sh7FFF, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, 16'sh8000, 0, 0));
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 0, 8'd1));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, -16'sd400, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, 16'sd400, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, -16'sd900, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sd900, 0, 0));
    send_beat(mk(CMD_END, 0, 0, 0, 0, 0));
    wait_drained();

    write_reg(REG_DIAG, 16'hFFFF);
    write_reg(REG_DEFSET, 16'd3);
    write_reg(REG_STEP, 16'd10);      // clamps up to the minimum
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 1, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sd300, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, 16'sd300, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, -16'sd700, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, -16'sd800, 0, 0));
    // Long receiver hold-off while the sender keeps offering.
    stall_hold = 400;
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sd2000, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, 16'sd50, 0, 0));
    send_beat(mk(CMD_EVENT, 1, AXIS_Y, -16'sd60, 0, 0));
    wait_drained();

    write_reg(REG_ENABLED, 16'd0);
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 0, 8'd2));
    send_beat(mk(CMD_EVENT, 1, AXIS_X, 16'sd999, 0, 0));
    wait_drained();

    write_reg(REG_ENABLED, 16'd1);
    write_reg(REG_STEP, 16'hFFFF);     // clamps down to the maximum
    write_reg(REG_DIAG, 16'h5A3C);
    write_reg(REG_DEFSET, 16'd1);
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 1, 0));
    random_phase(60);
    wait_drained();

    write_reg(REG_STEP, 16'd50);
    write_reg(REG_DIAG, 16'($urandom));
    write_reg(REG_DEFSET, 16'd2);
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 0, 8'($urandom)));
    random_phase(60);
    wait_drained();

    write_reg(REG_STEP, 16'd150);
    write_reg(REG_DIAG, 16'h0000);
    write_reg(REG_DEFSET, 16'd0);
    send_beat(mk(CMD_BEGIN, 0, 0, 0, 1, 0));
    random_phase(30);
    wait_drained();
    write_reg(REG_ENABLED, 16'd1);
    quiet_tail = 1;
    random_phase(30);

    in_valid_i <= 0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d input beats, %0d result beats (%0d fires),",
             items_sent, sb.beats_checked, sb.fires_seen);
    $display("under several step and mask settings, stalls and back-to-back offers.");
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/mgr_pkg.sv
hw/rtl/mgr_dir.sv
hw/rtl/motion_gesture_ratchet_core.sv
test/motion_gesture_ratchet_core_test.sv
